// ===== rtl/sacl_pkg.sv =====
`default_nettype none

package sacl_pkg;

    // default store geometry
    localparam int SETS_DEF  = 256;
    localparam int WAYS_DEF  = 8;

    // address bits taken from each access (the rest are masked off)
    localparam int ADDR_BITS = 32;

    localparam int ADDR_W    = 32;
    localparam int TAG_W     = 32;
    localparam int STAMP_W   = 32;
    localparam int CFG_W     = 4;
    localparam int WAY_OUT_W = 3;
    // widest raw set index that a 4-bit index_bits field can select
    localparam int RAW_W     = 15;

    localparam int APB_AW    = 4;
    localparam int APB_DW    = 32;

    // register indexes (byte address / 4)
    localparam logic [1:0] REG_OFFSET_BITS = 2'd0;
    localparam logic [1:0] REG_INDEX_BITS  = 2'd1;
    localparam logic [1:0] REG_WAYS_USED   = 2'd2;

    localparam logic [CFG_W-1:0] OFFSET_BITS_RST = 4'd5;
    localparam logic [CFG_W-1:0] INDEX_BITS_RST  = 4'd7;
    localparam logic [CFG_W-1:0] WAYS_USED_RST   = 4'd1;

    typedef enum logic [1:0] {
        OUT_HIT   = 2'd0,
        OUT_FILL  = 2'd1,
        OUT_EVICT = 2'd2
    } t_outcome;

    typedef struct packed {
        logic               vld;
        logic [TAG_W-1:0]   tag;
        logic [STAMP_W-1:0] stamp;
    } t_way_ent;

    localparam int OUT_DW = 40;

endpackage

`default_nettype wire

// ===== rtl/set_associative_cache_lru_tags_top.sv =====
`default_nettype none

// Tag-only set-associative cache with true LRU replacement. Each input beat on s_axis carries
// one byte address; each output beat on m_axis reports hit / fill / evict, the way used and the
// access ordinal (from one). One address is in flight at a time: a set's row (valid, tag and
// last-use stamp of every way) is read from a single synchronous memory, updated and written
// back before the next address is taken. A hit or a fill of an empty way passes accept, the
// set-index reduction modulo SETS (S_MOD1, then S_MOD2, which also reads the row), S_EVAL and
// S_WRITE; an eviction with more than one way in use adds the LRU scan (S_SCAN), one way at a
// time on the shared stamp comparator. The write-back waits while the previous result still
// sits unread in the output register. The next address is accepted in the cycle after the
// write-back, also while the result still waits in the output register. After reset a
// clearing pass writes every row, during which no address is accepted; the APB registers can
// be written anytime the block is idle, including during the clearing pass.
module set_associative_cache_lru_tags_top
    import sacl_pkg::*;
#(
    parameter int SETS = SETS_DEF,
    parameter int WAYS = WAYS_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // apb configuration
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic      [APB_DW-1:0] prdata,
    output logic                   pready,
    // input stream
    input  wire logic              s_axis_tvalid,
    output logic                   s_axis_tready,
    input  wire logic [ADDR_W-1:0] s_axis_tdata,   // [31:0] address
    // output stream
    output logic                   m_axis_tvalid,
    input  wire logic              m_axis_tready,
    output logic      [OUT_DW-1:0] m_axis_tdata    // [1:0] outcome, [4:2] way_chosen,
                                                   // [36:5] access_number, [39:37] zero
);

    localparam int SET_W  = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int NW_W   = $clog2(WAYS + 1);
    localparam int MOD_SH = RAW_W + SET_W;
    localparam longint unsigned MOD_MUL =
        ((longint'(1) << MOD_SH) + longint'(SETS) - 1) / longint'(SETS);
    localparam int MP_W   = RAW_W + MOD_SH + 1;
    localparam logic [ADDR_W-1:0] ADDR_MASK =
        (ADDR_BITS >= ADDR_W) ? '1 : ADDR_W'((64'd1 << ADDR_BITS) - 64'd1);

    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_MOD1  = 7'b0000100,
        S_MOD2  = 7'b0001000,
        S_EVAL  = 7'b0010000,
        S_SCAN  = 7'b0100000,
        S_WRITE = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    logic [CFG_W-1:0] r_offset_bits, r_index_bits, r_ways_used;

    t_way_ent [WAYS-1:0] r_mem [SETS];
    t_way_ent [WAYS-1:0] r_row;
    t_way_ent [WAYS-1:0] n_row;

    logic [SET_W-1:0]   r_clr_idx;
    logic [RAW_W-1:0]   r_idx_raw;
    logic [RAW_W-1:0]   r_quot;
    logic [SET_W-1:0]   r_set;
    logic [TAG_W-1:0]   r_tag;
    logic [WAY_W-1:0]   r_way;
    logic [WAY_W-1:0]   r_scan;
    logic [STAMP_W-1:0] r_best;
    t_outcome           r_outcome;
    logic [STAMP_W-1:0] r_acc_cnt;

    logic                 r_out_valid;
    t_outcome             r_out_outcome;
    logic [WAY_OUT_W-1:0] r_out_way;
    logic [STAMP_W-1:0]   r_out_num;

    // combinational helpers
    logic                cfg_wr;
    logic                in_acc;
    logic                out_free;
    logic [ADDR_W-1:0]   addr_m;
    logic [ADDR_W-1:0]   addr_sh;
    logic [RAW_W:0]      imask;
    logic [4:0]          tag_sh;
    logic [NW_W-1:0]     nways;
    logic [MP_W-1:0]     mod_prod;
    logic [SET_W-1:0]    set_idx;
    logic                hit_found, emp_found;
    logic [WAY_W-1:0]    hit_way, emp_way;
    logic                mem_we;
    logic [SET_W-1:0]    mem_wa;
    logic                scan_last;

    assign pready        = 1'b1;
    assign cfg_wr        = psel & penable & pwrite & pready;
    assign s_axis_tready = (r_state == S_IDLE);
    assign in_acc        = s_axis_tvalid & s_axis_tready;
    assign out_free      = !r_out_valid || m_axis_tready;

    always_comb begin
        case (paddr[3:2])
            REG_OFFSET_BITS: prdata = APB_DW'(r_offset_bits);
            REG_INDEX_BITS:  prdata = APB_DW'(r_index_bits);
            REG_WAYS_USED:   prdata = APB_DW'(r_ways_used);
            default:         prdata = '0;
        endcase
    end

    // field split of the incoming address
    assign addr_m  = s_axis_tdata & ADDR_MASK;
    assign addr_sh = addr_m >> r_offset_bits;
    assign imask   = ((RAW_W+1)'(1) << r_index_bits) - (RAW_W+1)'(1);
    assign tag_sh  = 5'(r_offset_bits) + 5'(r_index_bits);

    // ways in use: zero acts as one, anything above WAYS as WAYS
    always_comb begin
        if (r_ways_used == '0) begin
            nways = NW_W'(1);
        end else if (32'(r_ways_used) > WAYS) begin
            nways = NW_W'(WAYS);
        end else begin
            nways = NW_W'(r_ways_used);
        end
    end

    // set index modulo SETS by reciprocal multiply, exact for every 15-bit raw index
    assign mod_prod = MP_W'(r_idx_raw) * MP_W'(MOD_MUL);
    assign set_idx  = SET_W'(r_idx_raw - RAW_W'(32'(r_quot) * SETS));

    always_comb begin
        hit_found = 1'b0;
        emp_found = 1'b0;
        hit_way   = '0;
        emp_way   = '0;
        for (int i = 0; i < WAYS; i++) begin
            if (i < int'(nways)) begin
                if (!hit_found && r_row[i].vld && r_row[i].tag == r_tag) begin
                    hit_found = 1'b1;
                    hit_way   = WAY_W'(i);
                end
                if (!emp_found && !r_row[i].vld) begin
                    emp_found = 1'b1;
                    emp_way   = WAY_W'(i);
                end
            end
        end
    end

    assign scan_last = (NW_W'(r_scan) == nways - NW_W'(1));

    always_comb begin
        n_row = r_row;
        n_row[r_way].vld   = 1'b1;
        n_row[r_way].tag   = r_tag;
        n_row[r_way].stamp = r_acc_cnt;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (32'(r_clr_idx) == SETS - 1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_acc) begin
                    n_state = S_MOD1;
                end
            end
            S_MOD1:  n_state = S_MOD2;
            S_MOD2:  n_state = S_EVAL;
            S_EVAL: begin
                if (hit_found || emp_found || nways == NW_W'(1)) begin
                    n_state = S_WRITE;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (scan_last) begin
                    n_state = S_WRITE;
                end
            end
            S_WRITE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end

    assign mem_we = (r_state == S_CLEAR) || (r_state == S_WRITE && out_free);
    assign mem_wa = (r_state == S_CLEAR) ? r_clr_idx : r_set;

    // set memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= (r_state == S_CLEAR) ? '0 : n_row;
        end
        if (r_state == S_MOD2) begin
            r_row <= r_mem[set_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_CLEAR;
            r_clr_idx     <= '0;
            r_offset_bits <= OFFSET_BITS_RST;
            r_index_bits  <= INDEX_BITS_RST;
            r_ways_used   <= WAYS_USED_RST;
            r_acc_cnt     <= STAMP_W'(1);
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr_idx <= r_clr_idx + SET_W'(1);
            end
            if (cfg_wr) begin
                case (paddr[3:2])
                    REG_OFFSET_BITS: r_offset_bits <= pwdata[CFG_W-1:0];
                    REG_INDEX_BITS:  r_index_bits  <= pwdata[CFG_W-1:0];
                    REG_WAYS_USED:   r_ways_used   <= pwdata[CFG_W-1:0];
                    default: ;
                endcase
            end
            if (r_state == S_WRITE && out_free) begin
                r_acc_cnt   <= r_acc_cnt + STAMP_W'(1);
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_idx_raw <= addr_sh[RAW_W-1:0] & imask[RAW_W-1:0];
                r_tag     <= addr_m >> tag_sh;
            end
            S_MOD1: begin
                r_quot <= RAW_W'(mod_prod >> MOD_SH);
            end
            S_MOD2: begin
                r_set <= set_idx;
            end
            S_EVAL: begin
                if (hit_found) begin
                    r_outcome <= OUT_HIT;
                    r_way     <= hit_way;
                end else if (emp_found) begin
                    r_outcome <= OUT_FILL;
                    r_way     <= emp_way;
                end else begin
                    r_outcome <= OUT_EVICT;
                    r_way     <= '0;
                    r_best    <= r_row[0].stamp;
                    r_scan    <= WAY_W'(1);
                end
            end
            S_SCAN: begin
                // lowest way wins ties, so only a strictly smaller stamp moves the pick
                if (r_row[r_scan].stamp < r_best) begin
                    r_best <= r_row[r_scan].stamp;
                    r_way  <= r_scan;
                end
                r_scan <= r_scan + WAY_W'(1);
            end
            S_WRITE: begin
                if (out_free) begin
                    r_out_outcome <= r_outcome;
                    r_out_way     <= WAY_OUT_W'(r_way);
                    r_out_num     <= r_acc_cnt;
                end
            end
            default: ;
        endcase
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_DW'({r_out_num, r_out_way, r_out_outcome});

endmodule

`default_nettype wire

// ===== rtl/sacl_chk.sv =====
`default_nettype none

module sacl_chk
    import sacl_pkg::*;
(
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              s_axis_tvalid,
    input wire logic              s_axis_tready,
    input wire logic              m_axis_tvalid,
    input wire logic              m_axis_tready,
    input wire logic [OUT_DW-1:0] m_axis_tdata
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result beat changed while stalled");

    // the clearing pass follows reset, so no address is taken right after it
    a_clear_after_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !s_axis_tready)
        else $error("address accepted during clearing pass");

    // one address in flight: the cycle after an accept takes nothing
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second address accepted while one is in flight");

    a_outcome_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[1:0] == OUT_HIT || m_axis_tdata[1:0] == OUT_FILL
                           || m_axis_tdata[1:0] == OUT_EVICT))
        else $error("undefined outcome code");

    // a hit or fill never reports access number zero
    a_num_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) && m_axis_tdata[1:0] != OUT_EVICT |-> m_axis_tdata[36:5] != 32'd0
        || $past(m_axis_tvalid, 2))
        else $error("access number zero");

endmodule

bind set_associative_cache_lru_tags_top sacl_chk u_sacl_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

// ===== tb/tb.sv =====
`default_nettype none

module tb;
    import sacl_pkg::*;

    typedef struct packed {
        t_outcome              outcome;
        logic [WAY_OUT_W-1:0]  way;
        logic [STAMP_W-1:0]    acc_num;
    } t_lookup_res;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [APB_AW-1:0] paddr = '0;
    logic [APB_DW-1:0] pwdata = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [ADDR_W-1:0] s_axis_tdata = '0;   // [31:0] address

    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [OUT_DW-1:0] m_axis_tdata;       // [1:0] outcome, [4:2] way_chosen,
                                           // [36:5] access_number, [39:37] zero

    set_associative_cache_lru_tags_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 i_clk = ~i_clk;

    // shadow cache state
    bit                 vld_m   [SETS_DEF][WAYS_DEF];
    logic [TAG_W-1:0]   tag_m   [SETS_DEF][WAYS_DEF];
    logic [STAMP_W-1:0] stamp_m [SETS_DEF][WAYS_DEF];
    logic [STAMP_W-1:0] acc_cnt = 1;
    logic [CFG_W-1:0]   cfg_off = OFFSET_BITS_RST;
    logic [CFG_W-1:0]   cfg_idx = INDEX_BITS_RST;
    logic [CFG_W-1:0]   cfg_ways = WAYS_USED_RST;

    logic [ADDR_W-1:0] addr_q[$];
    t_lookup_res       lookup_res_q[$];

    int tx_idle_pct = 0;
    int rx_stall_pct = 0;
    int hold_req = 0;
    int hold_ack = 0;
    int hold_left = 0;
    int err_cnt = 0;

    function automatic t_lookup_res cache_lookup(input logic [ADDR_W-1:0] addr);
        logic [63:0]        a64;
        logic [63:0]        imask;
        int                 n;
        int                 sh;
        int                 set_i;
        logic [TAG_W-1:0]   tag;
        logic [STAMP_W-1:0] best;
        bit                 found;
        t_lookup_res        res;
        a64 = {32'd0, addr};
        n = (cfg_ways == 0) ? 1 : ((cfg_ways > WAYS_DEF) ? WAYS_DEF : int'(cfg_ways));
        sh = int'(cfg_off) + int'(cfg_idx);
        imask = (64'd1 << cfg_idx) - 64'd1;
        set_i = int'(((a64 >> cfg_off) & imask) % SETS_DEF);
        tag = TAG_W'(a64 >> sh);
        found = 1'b0;
        res.outcome = OUT_EVICT;
        res.way = '0;
        for (int i = 0; i < n && !found; i++) begin
            if (vld_m[set_i][i] && tag_m[set_i][i] == tag) begin
                res.outcome = OUT_HIT;
                res.way = WAY_OUT_W'(i);
                found = 1'b1;
            end
        end
        for (int i = 0; i < n && !found; i++) begin
            if (!vld_m[set_i][i]) begin
                res.outcome = OUT_FILL;
                res.way = WAY_OUT_W'(i);
                found = 1'b1;
            end
        end
        if (!found) begin
            // true lru, lowest way wins ties
            best = stamp_m[set_i][0];
            for (int i = 1; i < n; i++) begin
                if (stamp_m[set_i][i] < best) begin
                    best = stamp_m[set_i][i];
                    res.way = WAY_OUT_W'(i);
                end
            end
        end
        vld_m[set_i][res.way] = 1'b1;
        tag_m[set_i][res.way] = tag;
        stamp_m[set_i][res.way] = acc_cnt;
        res.acc_num = acc_cnt;
        acc_cnt = acc_cnt + 1;
        return res;
    endfunction

    // address driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (s_axis_tvalid)
                lookup_res_q.push_back(cache_lookup(s_axis_tdata));
            if (addr_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= addr_q.pop_front();
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // result receiver, with an occasional long hold-off
    always @(posedge i_clk) begin
        if (hold_req != hold_ack) begin
            hold_ack <= hold_req;
            hold_left <= 300;
            m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_lookup_res exp_r;
        t_lookup_res got_r;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got_r.outcome = t_outcome'(m_axis_tdata[1:0]);
            got_r.way = m_axis_tdata[4:2];
            got_r.acc_num = m_axis_tdata[36:5];
            if (lookup_res_q.size() == 0) begin
                err_cnt <= err_cnt + 1;
                if (err_cnt < 10)
                    $display("unexpected result beat: outcome %0d way %0d num %0d",
                             got_r.outcome, got_r.way, got_r.acc_num);
            end else begin
                exp_r = lookup_res_q.pop_front();
                if (got_r != exp_r) begin
                    err_cnt <= err_cnt + 1;
                    if (err_cnt < 10)
                        $display("bad result: exp outcome %0d way %0d num %0d, got %0d %0d %0d",
                                 exp_r.outcome, exp_r.way, exp_r.acc_num,
                                 got_r.outcome, got_r.way, got_r.acc_num);
                end
            end
        end
    end

    task automatic apb_write(input logic [1:0] idx, input logic [CFG_W-1:0] val);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= APB_AW'({idx, 2'b00});
        pwdata <= APB_DW'(val);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_OFFSET_BITS: cfg_off = val;
            REG_INDEX_BITS:  cfg_idx = val;
            REG_WAYS_USED:   cfg_ways = val;
            default: ;
        endcase
    endtask

    task automatic set_geometry(input logic [CFG_W-1:0] off, input logic [CFG_W-1:0] idx,
                                input logic [CFG_W-1:0] ways);
        apb_write(REG_OFFSET_BITS, off);
        apb_write(REG_INDEX_BITS, idx);
        apb_write(REG_WAYS_USED, ways);
    endtask

    task automatic wait_drained();
        do @(posedge i_clk);
        while (addr_q.size() != 0 || s_axis_tvalid || lookup_res_q.size() != 0);
        repeat (20) @(posedge i_clk);
    endtask

    function automatic logic [ADDR_W-1:0] pick_addr(input logic [ADDR_W-1:0] pool[16]);
        int r;
        int k;
        int sh;
        r = $urandom_range(99);
        k = $urandom_range(15);
        sh = int'(cfg_off) + int'(cfg_idx);
        if (r < 40)
            return pool[k];
        else if (r < 60)
            return pool[k] ^ ($urandom & ((32'd1 << cfg_off) - 32'd1));
        else if (r < 80)
            return pool[k] ^ ($urandom << sh);     // same set, other tag
        else
            return $urandom;
    endfunction

    initial begin
        logic [CFG_W-1:0]  geo[8][3];
        logic [ADDR_W-1:0] pool[16];
        geo = '{'{4'd5, 4'd7, 4'd1}, '{4'd0, 4'd0, 4'd8}, '{4'd2, 4'd3, 4'd4},
                '{4'd8, 4'd0, 4'd15}, '{4'd4, 4'd2, 4'd2}, '{4'd15, 4'd15, 4'd0},
                '{4'd1, 4'd1, 4'd9}, '{4'd3, 4'd8, 4'd8}};
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset geometry, one way: extremes, hit in same block, conflict eviction
        addr_q = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_001F,
                   32'h0000_1000};
        wait_drained();

        // single set holding whole addresses as tags: fill, hit, lru evictions
        set_geometry(4'd0, 4'd0, 4'd8);
        for (int i = 0; i < 8; i++)
            addr_q.push_back(32'h100 + i);
        addr_q.push_back(32'h100);
        addr_q.push_back(32'h200);
        addr_q.push_back(32'h300);
        addr_q.push_back(32'h102);
        wait_drained();

        // huge bit counts with ways of zero, then ways above the store
        set_geometry(4'd15, 4'd15, 4'd0);
        addr_q = '{32'hC000_0000, 32'h4000_0000, 32'hC000_0000};
        wait_drained();
        set_geometry(4'd3, 4'd4, 4'd15);
        addr_q = '{32'h1234_5678, 32'hEDCB_A987, 32'h1234_5678};
        wait_drained();

        for (int ph = 0; ph < 8; ph++) begin
            set_geometry(geo[ph][0], geo[ph][1], geo[ph][2]);
            case (ph % 4)
                0: begin tx_idle_pct <= 0;  rx_stall_pct <= 0;  end
                1: begin tx_idle_pct <= 56; rx_stall_pct <= 0;  end
                2: begin tx_idle_pct <= 0;  rx_stall_pct <= 56; end
                default: begin tx_idle_pct <= 14; rx_stall_pct <= 14; end
            endcase
            foreach (pool[i])
                pool[i] = $urandom;
            // two bursts per phase, the sender waits for all results in between
            for (int c = 0; c < 2; c++) begin
                for (int i = 0; i < 82; i++)
                    addr_q.push_back(pick_addr(pool));
                if (ph % 4 == 0 && c == 0)
                    hold_req <= hold_req + 1;
                wait_drained();
            end
        end

        if (err_cnt == 0 && lookup_res_q.size() == 0)
            $display("set_associative_cache_lru_tags_top: match");
        else
            $display("set_associative_cache_lru_tags_top: mismatch");
        $finish;
    end

    initial begin
        #3000000;
        $display("set_associative_cache_lru_tags_top: mismatch");
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
rtl/sacl_pkg.sv
rtl/set_associative_cache_lru_tags_top.sv
rtl/sacl_chk.sv
tb/tb.sv
